// ===== rtl/core/crt_pkg.sv =====
// Shared types, codes and defaults for the congruence merger.
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int MODULUS_BITS_DEF = 32;
    localparam int RESULT_BITS_DEF  = 64;
    localparam int IN_FIELD_W       = 32;
    localparam int OUT_FIELD_W      = 64;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_SOLUTION = 2'd1,
        STATUS_OVERFLOW    = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RRED,
        ST_FIRST,
        ST_GCD_INIT,
        ST_GCD,
        ST_RMODG,
        ST_SMODG,
        ST_CMP,
        ST_MPDIV,
        ST_OVDIV,
        ST_OVCHK,
        ST_SMODM,
        ST_DSUB,
        ST_DMOD,
        ST_QDIV,
        ST_ADIV,
        ST_AMOD,
        ST_INV,
        ST_INVMUL,
        ST_INVFIX,
        ST_TMUL,
        ST_TMOD,
        ST_SMUL,
        ST_MMUL,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZERO,
        OP_RRED,
        OP_FIRST,
        OP_GCD_INIT,
        OP_GCD,
        OP_GCD_DONE,
        OP_RMODG,
        OP_SMODG,
        OP_CMP,
        OP_MPDIV,
        OP_OVDIV,
        OP_OVCHK,
        OP_SMODM,
        OP_DSUB,
        OP_DMOD,
        OP_QDIV,
        OP_ADIV,
        OP_AMOD,
        OP_INV,
        OP_INVMUL,
        OP_INVFIX,
        OP_TMUL,
        OP_TMOD,
        OP_SMUL,
        OP_MMUL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
        logic mul_start;
    } cmd_t;

    typedef struct packed {
        logic m_zero;
        logic y_zero;
        logic neq;
        logic over;
        logic fault;
        logic have_first;
        logic last;
        logic arith_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/crt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crt_divider #(
    parameter int W = 66
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic [W:0]    shifted;
    logic          ge;
    logic [W-1:0]  rem_new;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        rem_new = ge ? W'(shifted - {1'b0, dvs_reg}) : shifted[W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crt_multiplier.sv =====
// Shift-and-add multiplier, product truncated to W bits, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crt_multiplier #(
    parameter int W = 66
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] op_a,
    input  wire logic [W-1:0] op_b,
    output logic              done,
    output logic [W-1:0]      product
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, a_reg, b_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crt_datapath.sv =====
// Datapath: working registers, shared divider and multiplier, result register.
`timescale 1ns / 1ps
`default_nettype none

module crt_datapath #(
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF,
    parameter int RESULT_BITS  = crt_pkg::RESULT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire crt_pkg::cmd_t                    cmd,
    output crt_pkg::stat_t                        stat,
    input  wire logic [crt_pkg::IN_FIELD_W-1:0]   residue,
    input  wire logic [crt_pkg::IN_FIELD_W-1:0]   modulus,
    input  wire logic                             last_item,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [crt_pkg::OUT_FIELD_W-1:0]       solution,
    output logic [crt_pkg::OUT_FIELD_W-1:0]       combined_modulus,
    output logic [1:0]                            status
);

    // headroom for Euclid coefficients and the q * inv product
    localparam int WB = (RESULT_BITS > 2 * MODULUS_BITS) ? RESULT_BITS : 2 * MODULUS_BITS;
    localparam int W  = WB + 2;
    localparam logic [W-1:0] RES_MASK = {{(W - RESULT_BITS){1'b0}}, {RESULT_BITS{1'b1}}};

    logic [W-1:0] r_reg, m_reg, sol_reg, mod_reg, x_reg, y_reg, g_reg, mp_reg;
    logic [W-1:0] tmp_reg, tmp2_reg, qv_reg, quo_reg, s0_reg, s1_reg;
    logic         last_reg;
    logic         have_reg, conflict_reg, overflow_reg, out_valid_reg;
    logic [crt_pkg::OUT_FIELD_W-1:0] sol_out_reg, mod_out_reg;
    logic [1:0]   status_reg;

    logic [W-1:0] div_a, div_b, mul_a, mul_b;
    logic [W-1:0] quot, rem, prod;
    logic         div_done, mul_done;
    logic         emit;

    always_comb
    begin
        div_a = r_reg;
        div_b = m_reg;
        unique case (cmd.op)
            crt_pkg::OP_GCD:   begin div_a = x_reg;    div_b = y_reg;  end
            crt_pkg::OP_INV:   begin div_a = x_reg;    div_b = y_reg;  end
            crt_pkg::OP_RMODG: begin div_a = r_reg;    div_b = g_reg;  end
            crt_pkg::OP_SMODG: begin div_a = sol_reg;  div_b = g_reg;  end
            crt_pkg::OP_MPDIV: begin div_a = m_reg;    div_b = g_reg;  end
            crt_pkg::OP_OVDIV: begin div_a = RES_MASK; div_b = mp_reg; end
            crt_pkg::OP_SMODM: begin div_a = sol_reg;  div_b = m_reg;  end
            crt_pkg::OP_DMOD:  begin div_a = tmp_reg;  div_b = m_reg;  end
            crt_pkg::OP_QDIV:  begin div_a = tmp_reg;  div_b = g_reg;  end
            crt_pkg::OP_ADIV:  begin div_a = mod_reg;  div_b = g_reg;  end
            crt_pkg::OP_AMOD:  begin div_a = tmp_reg;  div_b = mp_reg; end
            crt_pkg::OP_TMOD:  begin div_a = tmp_reg;  div_b = mp_reg; end
            default:           begin div_a = r_reg;    div_b = m_reg;  end
        endcase
    end

    always_comb
    begin
        unique case (cmd.op)
            crt_pkg::OP_INVMUL: begin mul_a = quo_reg; mul_b = s1_reg;  end
            crt_pkg::OP_TMUL:   begin mul_a = qv_reg;  mul_b = x_reg;   end
            crt_pkg::OP_SMUL:   begin mul_a = mod_reg; mul_b = tmp_reg; end
            default:            begin mul_a = mod_reg; mul_b = mp_reg;  end
        endcase
    end

    crt_divider #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    crt_multiplier #(.W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign emit = (cmd.op == crt_pkg::OP_EMIT);

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            crt_pkg::OP_LOAD:
            begin
                r_reg    <= W'(residue[MODULUS_BITS-1:0]);
                m_reg    <= W'(modulus[MODULUS_BITS-1:0]);
                last_reg <= last_item;
            end
            crt_pkg::OP_RRED:  if (div_done) r_reg <= rem;
            crt_pkg::OP_FIRST:
            begin
                sol_reg <= r_reg;
                mod_reg <= m_reg;
            end
            crt_pkg::OP_GCD_INIT:
            begin
                x_reg <= mod_reg;
                y_reg <= m_reg;
            end
            crt_pkg::OP_GCD:
            begin
                if (div_done)
                begin
                    x_reg <= y_reg;
                    y_reg <= rem;
                end
            end
            crt_pkg::OP_GCD_DONE: g_reg <= x_reg;
            crt_pkg::OP_RMODG: if (div_done) tmp_reg  <= rem;
            crt_pkg::OP_SMODG: if (div_done) tmp2_reg <= rem;
            crt_pkg::OP_MPDIV: if (div_done) mp_reg   <= quot;
            crt_pkg::OP_OVDIV: if (div_done) tmp_reg  <= quot;
            crt_pkg::OP_SMODM: if (div_done) tmp_reg  <= rem;
            crt_pkg::OP_DSUB:  tmp_reg <= r_reg + m_reg - tmp_reg;
            crt_pkg::OP_DMOD:  if (div_done) tmp_reg  <= rem;
            crt_pkg::OP_QDIV:  if (div_done) qv_reg   <= quot;
            crt_pkg::OP_ADIV:  if (div_done) tmp_reg  <= quot;
            crt_pkg::OP_AMOD:
            begin
                if (div_done)
                begin
                    x_reg  <= rem;
                    y_reg  <= mp_reg;
                    s0_reg <= W'(1);
                    s1_reg <= '0;
                end
            end
            crt_pkg::OP_INV:
            begin
                if (div_done)
                begin
                    x_reg   <= y_reg;
                    y_reg   <= rem;
                    quo_reg <= quot;
                end
            end
            crt_pkg::OP_INVMUL:
            begin
                if (mul_done)
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg - prod;
                end
            end
            // coefficient is two's complement; fold a negative one into range
            crt_pkg::OP_INVFIX: x_reg <= s0_reg[W-1] ? s0_reg + mp_reg : s0_reg;
            crt_pkg::OP_TMUL:  if (mul_done) tmp_reg  <= prod;
            crt_pkg::OP_TMOD:  if (div_done) tmp_reg  <= rem;
            crt_pkg::OP_SMUL:  if (mul_done) tmp2_reg <= prod;
            crt_pkg::OP_MMUL:
            begin
                if (mul_done)
                begin
                    mod_reg <= prod;
                    sol_reg <= sol_reg + tmp2_reg;
                end
            end
            default: ;
        endcase
    end

    // set flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            conflict_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            priority if (emit)
            begin
                have_reg     <= 1'b0;
                conflict_reg <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.op == crt_pkg::OP_FIRST)
            begin
                have_reg <= 1'b1;
            end
            else if (cmd.op == crt_pkg::OP_ZERO)
            begin
                conflict_reg <= 1'b1;
            end
            else if (cmd.op == crt_pkg::OP_CMP && tmp_reg != tmp2_reg)
            begin
                conflict_reg <= 1'b1;
            end
            else if (cmd.op == crt_pkg::OP_OVCHK && mod_reg > tmp_reg)
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            priority if (conflict_reg)
            begin
                sol_out_reg <= '0;
                mod_out_reg <= '0;
                status_reg  <= crt_pkg::STATUS_NO_SOLUTION;
            end
            else if (overflow_reg)
            begin
                sol_out_reg <= '0;
                mod_out_reg <= '0;
                status_reg  <= crt_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                sol_out_reg <= crt_pkg::OUT_FIELD_W'(sol_reg[RESULT_BITS-1:0]);
                mod_out_reg <= crt_pkg::OUT_FIELD_W'(mod_reg[RESULT_BITS-1:0]);
                status_reg  <= crt_pkg::STATUS_OK;
            end
        end
    end

    always_comb
    begin
        stat.m_zero     = (m_reg == '0);
        stat.y_zero     = (y_reg == '0);
        stat.neq        = (tmp_reg != tmp2_reg);
        stat.over       = (mod_reg > tmp_reg);
        stat.fault      = conflict_reg | overflow_reg;
        stat.have_first = have_reg;
        stat.last       = last_reg;
        stat.arith_done = div_done | mul_done;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign solution         = sol_out_reg;
    assign combined_modulus = mod_out_reg;
    assign status           = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crt_ctrl.sv =====
// Controller: sequences the merge of one congruence over the shared units.
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire crt_pkg::stat_t stat,
    output crt_pkg::cmd_t       cmd
);

    crt_pkg::state_t state_reg, state_next;
    logic            launched_reg, launched_next;
    logic            div_go, mul_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= crt_pkg::ST_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = crt_pkg::OP_NONE;
        div_go     = 1'b0;
        mul_go     = 1'b0;
        unique case (state_reg)
            crt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = crt_pkg::OP_LOAD;
                    state_next = crt_pkg::ST_CHECK;
                end
            end
            crt_pkg::ST_CHECK:
            begin
                priority if (stat.fault)
                begin
                    state_next = crt_pkg::ST_FINISH;
                end
                else if (stat.m_zero)
                begin
                    cmd.op     = crt_pkg::OP_ZERO;
                    state_next = crt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = crt_pkg::ST_RRED;
                end
            end
            crt_pkg::ST_RRED:
            begin
                cmd.op = crt_pkg::OP_RRED;
                div_go = 1'b1;
                if (stat.arith_done)
                begin
                    state_next = stat.have_first ? crt_pkg::ST_GCD_INIT : crt_pkg::ST_FIRST;
                end
            end
            crt_pkg::ST_FIRST:
            begin
                cmd.op     = crt_pkg::OP_FIRST;
                state_next = crt_pkg::ST_FINISH;
            end
            crt_pkg::ST_GCD_INIT:
            begin
                cmd.op     = crt_pkg::OP_GCD_INIT;
                state_next = crt_pkg::ST_GCD;
            end
            crt_pkg::ST_GCD:
            begin
                if (stat.y_zero)
                begin
                    cmd.op     = crt_pkg::OP_GCD_DONE;
                    state_next = crt_pkg::ST_RMODG;
                end
                else
                begin
                    cmd.op = crt_pkg::OP_GCD;
                    div_go = 1'b1;
                end
            end
            crt_pkg::ST_RMODG:
            begin
                cmd.op = crt_pkg::OP_RMODG;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_SMODG;
            end
            crt_pkg::ST_SMODG:
            begin
                cmd.op = crt_pkg::OP_SMODG;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_CMP;
            end
            crt_pkg::ST_CMP:
            begin
                cmd.op     = crt_pkg::OP_CMP;
                state_next = stat.neq ? crt_pkg::ST_FINISH : crt_pkg::ST_MPDIV;
            end
            crt_pkg::ST_MPDIV:
            begin
                cmd.op = crt_pkg::OP_MPDIV;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_OVDIV;
            end
            crt_pkg::ST_OVDIV:
            begin
                cmd.op = crt_pkg::OP_OVDIV;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_OVCHK;
            end
            crt_pkg::ST_OVCHK:
            begin
                cmd.op     = crt_pkg::OP_OVCHK;
                state_next = stat.over ? crt_pkg::ST_FINISH : crt_pkg::ST_SMODM;
            end
            crt_pkg::ST_SMODM:
            begin
                cmd.op = crt_pkg::OP_SMODM;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_DSUB;
            end
            crt_pkg::ST_DSUB:
            begin
                cmd.op     = crt_pkg::OP_DSUB;
                state_next = crt_pkg::ST_DMOD;
            end
            crt_pkg::ST_DMOD:
            begin
                cmd.op = crt_pkg::OP_DMOD;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_QDIV;
            end
            crt_pkg::ST_QDIV:
            begin
                cmd.op = crt_pkg::OP_QDIV;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_ADIV;
            end
            crt_pkg::ST_ADIV:
            begin
                cmd.op = crt_pkg::OP_ADIV;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_AMOD;
            end
            crt_pkg::ST_AMOD:
            begin
                cmd.op = crt_pkg::OP_AMOD;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_INV;
            end
            crt_pkg::ST_INV:
            begin
                if (stat.y_zero)
                begin
                    state_next = crt_pkg::ST_INVFIX;
                end
                else
                begin
                    cmd.op = crt_pkg::OP_INV;
                    div_go = 1'b1;
                    if (stat.arith_done) state_next = crt_pkg::ST_INVMUL;
                end
            end
            crt_pkg::ST_INVMUL:
            begin
                cmd.op = crt_pkg::OP_INVMUL;
                mul_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_INV;
            end
            crt_pkg::ST_INVFIX:
            begin
                cmd.op     = crt_pkg::OP_INVFIX;
                state_next = crt_pkg::ST_TMUL;
            end
            crt_pkg::ST_TMUL:
            begin
                cmd.op = crt_pkg::OP_TMUL;
                mul_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_TMOD;
            end
            crt_pkg::ST_TMOD:
            begin
                cmd.op = crt_pkg::OP_TMOD;
                div_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_SMUL;
            end
            crt_pkg::ST_SMUL:
            begin
                cmd.op = crt_pkg::OP_SMUL;
                mul_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_MMUL;
            end
            crt_pkg::ST_MMUL:
            begin
                cmd.op = crt_pkg::OP_MMUL;
                mul_go = 1'b1;
                if (stat.arith_done) state_next = crt_pkg::ST_FINISH;
            end
            crt_pkg::ST_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = crt_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = crt_pkg::OP_EMIT;
                    state_next = crt_pkg::ST_IDLE;
                end
            end
            default: state_next = crt_pkg::ST_IDLE;
        endcase

        // one start pulse per unit operation, held off until done
        cmd.div_start = div_go && !launched_reg;
        cmd.mul_start = mul_go && !launched_reg;
        launched_next = (div_go || mul_go) && !stat.arith_done;
    end

    assign in_stall = (state_reg != crt_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/crt_congruence_merger_top.sv =====
// Top level of the congruence merger: controller plus datapath.
//
//  channel | direction | handshake             | beat payload
//  in      | input     | in_valid / in_stall   | residue, modulus, last_item
//  out     | output    | out_valid / out_stall | solution, combined_modulus, status
//
// One congruence at a time; in_stall is high whenever the controller is not idle.
// Divides and multiplies share one iterative divider and one multiplier, each W bits wide,
// W = max(RESULT_BITS, 2*MODULUS_BITS)+2, so 66 at the defaults. The first beat of a set runs
// one divide; a later beat runs 14 such operations plus one per gcd step and two per
// inverse step.
// Reset clears the controller and the set flags; no clearing pass.
// A stalled result sits in the output register; the next beat is still taken, and
// only the emit of a further result waits for that register to drain.
`timescale 1ns / 1ps
`default_nettype none

module crt_congruence_merger_top #(
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF,
    parameter int RESULT_BITS  = crt_pkg::RESULT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [crt_pkg::IN_FIELD_W-1:0] residue,
    input  wire logic [crt_pkg::IN_FIELD_W-1:0] modulus,
    input  wire logic                           last_item,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [crt_pkg::OUT_FIELD_W-1:0]     solution,
    output logic [crt_pkg::OUT_FIELD_W-1:0]     combined_modulus,
    output logic [1:0]                          status
);

    crt_pkg::cmd_t  cmd;
    crt_pkg::stat_t stat;

    crt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    crt_datapath #(
        .MODULUS_BITS (MODULUS_BITS),
        .RESULT_BITS  (RESULT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .residue          (residue),
        .modulus          (modulus),
        .last_item        (last_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .solution         (solution),
        .combined_modulus (combined_modulus),
        .status           (status)
    );

    a_fault_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != crt_pkg::STATUS_OK |-> solution == '0 && combined_modulus == '0)
        else $error("faulted result carries nonzero payload");

    a_ok_mod_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == crt_pkg::STATUS_OK |-> combined_modulus != '0)
        else $error("ok result with zero combined modulus");

    a_ok_sol_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == crt_pkg::STATUS_OK |-> solution < combined_modulus)
        else $error("solution not reduced below combined modulus");

    a_no_double_unit : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_start && cmd.mul_start))
        else $error("divider and multiplier started together");

endmodule

`default_nettype wire
